[rtl/rled_pkg.sv]
package rled_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;
    localparam logic [3:0]  MAX_FIELD_CNT   = 4'(MAX_FIELD_BYTES);
    localparam int unsigned WORD_LANES      = 8;
    localparam int unsigned Q_DEPTH         = 4;
    localparam int unsigned Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W         = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_RUN   = 3'd0,
        KIND_OK    = 3'd1,
        KIND_BAD   = 3'd2,
        KIND_TRUNC = 3'd3,
        KIND_UNDER = 3'd4,
        KIND_EMPTY = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2,
        PH_DRAIN  = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] start_virtual;
        logic [63:0] cluster;
        logic [63:0] length;
        logic        sparse;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

[rtl/rled_in_reg.sv]
module rled_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_end_of_buffer
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eob;
    logic       n_valid;
    logic       load;

    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_data_byte;
            r_eob  <= i_end_of_buffer;
        end
    end

    assign o_valid         = r_valid;
    assign o_data_byte     = r_byte;
    assign o_end_of_buffer = r_eob;

endmodule

[rtl/rled_core.sv]
module rled_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_byte,
    input  logic           i_eob,
    output rled_pkg::t_push o_push
);

    rled_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_len_bytes, n_len_bytes;
    logic [3:0]       r_off_bytes, n_off_bytes;
    logic [3:0]       r_pos, n_pos;
    logic [63:0]      r_len_acc, n_len_acc;
    logic [63:0]      r_off_acc, n_off_acc;
    logic [63:0]      r_virt, n_virt;
    logic [63:0]      r_cluster, n_cluster;
    logic             r_any_run, n_any_run;

    logic [3:0]  ls;
    logic [3:0]  os;
    logic        hdr_zero;
    logic        hdr_bad;
    logic [3:0]  pos_inc;
    logic        len_done;
    logic        off_done;
    logic [63:0] merged_len;
    logic [63:0] merged_off;
    logic [63:0] delta;
    logic [64:0] clu_sum;
    logic        under;
    logic [63:0] run_len;
    logic [63:0] virt_sum;

    assign ls       = i_byte[3:0];
    assign os       = i_byte[7:4];
    assign hdr_zero = (i_byte == 8'd0);
    assign hdr_bad  = (ls == 4'd0) || (ls > rled_pkg::MAX_FIELD_CNT)
                   || (os > rled_pkg::MAX_FIELD_CNT);
    assign pos_inc  = r_pos + 4'd1;
    assign len_done = (pos_inc >= r_len_bytes);
    assign off_done = (pos_inc >= r_off_bytes);

    always_comb begin
        for (int k = 0; k < rled_pkg::WORD_LANES; k++) begin
            merged_len[8*k +: 8] = (3'(k) == r_pos[2:0]) ? i_byte : r_len_acc[8*k +: 8];
            merged_off[8*k +: 8] = (3'(k) == r_pos[2:0]) ? i_byte : r_off_acc[8*k +: 8];
            if (r_phase != rled_pkg::PH_OFFSET) begin
                delta[8*k +: 8] = 8'd0;
            end else if (3'(k) < r_pos[2:0]) begin
                delta[8*k +: 8] = r_off_acc[8*k +: 8];
            end else if (3'(k) == r_pos[2:0]) begin
                delta[8*k +: 8] = i_byte;
            end else begin
                delta[8*k +: 8] = {8{i_byte[7]}};
            end
        end
    end

    assign clu_sum  = {1'b0, r_cluster} + {1'b0, delta};
    assign under    = delta[63] && !clu_sum[64];
    assign run_len  = (r_phase == rled_pkg::PH_LENGTH) ? merged_len : r_len_acc;
    assign virt_sum = r_virt + run_len;

    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            if (i_eob) begin
                n_phase = rled_pkg::PH_HEADER;
            end else begin
                case (r_phase)
                    rled_pkg::PH_HEADER: begin
                        if (hdr_zero || hdr_bad) begin
                            n_phase = rled_pkg::PH_DRAIN;
                        end else begin
                            n_phase = rled_pkg::PH_LENGTH;
                        end
                    end
                    rled_pkg::PH_LENGTH: begin
                        if (len_done) begin
                            n_phase = (r_off_bytes == 4'd0) ? rled_pkg::PH_HEADER
                                                            : rled_pkg::PH_OFFSET;
                        end
                    end
                    rled_pkg::PH_OFFSET: begin
                        if (off_done) begin
                            n_phase = under ? rled_pkg::PH_DRAIN : rled_pkg::PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_len_bytes = r_len_bytes;
        n_off_bytes = r_off_bytes;
        n_pos       = r_pos;
        n_len_acc   = r_len_acc;
        n_off_acc   = r_off_acc;
        n_virt      = r_virt;
        n_cluster   = r_cluster;
        n_any_run   = r_any_run;
        if (i_fire) begin
            if (i_eob) begin
                n_len_bytes = 4'd0;
                n_off_bytes = 4'd0;
                n_pos       = 4'd0;
                n_len_acc   = '0;
                n_off_acc   = '0;
                n_virt      = '0;
                n_cluster   = '0;
                n_any_run   = 1'b0;
            end else begin
                case (r_phase)
                    rled_pkg::PH_HEADER: begin
                        if (!hdr_zero && !hdr_bad) begin
                            n_len_bytes = ls;
                            n_off_bytes = os;
                            n_pos       = 4'd0;
                            n_len_acc   = '0;
                            n_off_acc   = '0;
                        end
                    end
                    rled_pkg::PH_LENGTH: begin
                        n_len_acc = merged_len;
                        if (len_done) begin
                            n_pos = 4'd0;
                            if (r_off_bytes == 4'd0) begin
                                n_virt    = virt_sum;
                                n_any_run = 1'b1;
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    rled_pkg::PH_OFFSET: begin
                        n_off_acc = merged_off;
                        if (off_done) begin
                            n_pos = 4'd0;
                            if (!under) begin
                                n_cluster = clu_sum[63:0];
                                n_virt    = virt_sum;
                                n_any_run = 1'b1;
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    default: begin
                        n_pos = r_pos;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_push        = '0;
        o_push.second.kind = rled_pkg::KIND_OK;
        o_push.second.last = 1'b1;
        o_push.first.kind  = rled_pkg::KIND_RUN;
        case (r_phase)
            rled_pkg::PH_HEADER: begin
                if (hdr_zero) begin
                    o_push.count      = 2'd1;
                    o_push.first.kind = r_any_run ? rled_pkg::KIND_OK : rled_pkg::KIND_EMPTY;
                end else if (hdr_bad) begin
                    o_push.count      = 2'd1;
                    o_push.first.kind = rled_pkg::KIND_BAD;
                end else if (i_eob) begin
                    o_push.count      = 2'd1;
                    o_push.first.kind = rled_pkg::KIND_TRUNC;
                end
            end
            rled_pkg::PH_LENGTH: begin
                if (len_done && (r_off_bytes == 4'd0)) begin
                    o_push.count               = i_eob ? 2'd2 : 2'd1;
                    o_push.first.kind          = rled_pkg::KIND_RUN;
                    o_push.first.start_virtual = r_virt;
                    o_push.first.cluster       = r_cluster;
                    o_push.first.length        = merged_len;
                    o_push.first.sparse        = 1'b1;
                end else if (i_eob) begin
                    o_push.count      = 2'd1;
                    o_push.first.kind = rled_pkg::KIND_TRUNC;
                end
            end
            rled_pkg::PH_OFFSET: begin
                if (off_done && under) begin
                    o_push.count      = 2'd1;
                    o_push.first.kind = rled_pkg::KIND_UNDER;
                end else if (off_done) begin
                    o_push.count               = i_eob ? 2'd2 : 2'd1;
                    o_push.first.kind          = rled_pkg::KIND_RUN;
                    o_push.first.start_virtual = r_virt;
                    o_push.first.cluster       = clu_sum[63:0];
                    o_push.first.length        = r_len_acc;
                end else if (i_eob) begin
                    o_push.count      = 2'd1;
                    o_push.first.kind = rled_pkg::KIND_TRUNC;
                end
            end
            default: begin
                o_push.count = 2'd0;
            end
        endcase
        o_push.first.last = (o_push.count == 2'd1);
        if (!i_fire) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rled_pkg::PH_HEADER;
            r_len_bytes <= 4'd0;
            r_off_bytes <= 4'd0;
            r_pos       <= 4'd0;
            r_len_acc   <= '0;
            r_off_acc   <= '0;
            r_virt      <= '0;
            r_cluster   <= '0;
            r_any_run   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len_bytes <= n_len_bytes;
            r_off_bytes <= n_off_bytes;
            r_pos       <= n_pos;
            r_len_acc   <= n_len_acc;
            r_off_acc   <= n_off_acc;
            r_virt      <= n_virt;
            r_cluster   <= n_cluster;
            r_any_run   <= n_any_run;
        end
    end

`ifndef SYNTHESIS
    a_eob_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eob) |=> (r_phase == rled_pkg::PH_HEADER && r_virt == '0
                               && r_cluster == '0 && !r_any_run))
        else $error("state not cleared after end of buffer");

    a_pair_is_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (o_push.first.kind == rled_pkg::KIND_RUN && i_eob))
        else $error("second result without a closing run");

    a_drain_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rled_pkg::PH_DRAIN) |-> (o_push.count == 2'd0))
        else $error("result while draining");

    a_run_marks_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd1 && o_push.first.kind == rled_pkg::KIND_RUN)
        |=> (r_any_run && r_phase == rled_pkg::PH_HEADER))
        else $error("run emitted without state update");
`endif

endmodule

[rtl/rled_res_q.sv]
module rled_res_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rled_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output rled_pkg::t_result o_head
);

    rled_pkg::t_result              r_mem [rled_pkg::Q_DEPTH];
    logic [rled_pkg::Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [rled_pkg::Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [rled_pkg::Q_CNT_W-1:0]   r_count, n_count;
    logic [rled_pkg::Q_PTR_W-1:0]   wr_ptr_nx;
    logic                           pop;

    assign pop       = i_pop && o_valid;
    assign wr_ptr_nx = r_wr_ptr + rled_pkg::Q_PTR_W'(1);
    assign n_wr_ptr  = r_wr_ptr + rled_pkg::Q_PTR_W'(i_push.count);
    assign n_rd_ptr  = pop ? r_rd_ptr + rled_pkg::Q_PTR_W'(1) : r_rd_ptr;
    assign n_count   = r_count + rled_pkg::Q_CNT_W'(i_push.count)
                     - rled_pkg::Q_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_nx] <= i_push.second;
        end
    end

    assign o_room  = (r_count <= rled_pkg::Q_CNT_W'(rled_pkg::Q_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

[rtl/run_list_extent_decoder_unit.sv]
// A request's first result passes the input register, then the decode step writes it into the
// result queue, whose head drives the outputs; while the queue lacks room the byte waits.
// Throughput: one byte per cycle while the result queue has room; a byte that closes the list
// with a run yields two results at once. The 4-entry result queue sets the input backpressure.
// Reset: i_rst_n is synchronous, active low; it clears decode state, the input register and
// the result queue at once.
module run_list_extent_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [63:0] o_run_start_virtual,
    output logic [63:0] o_run_cluster,
    output logic [63:0] o_run_length,
    output logic        o_sparse_run,
    output logic        o_last_result
);

    logic              req_valid;
    logic [7:0]        req_byte;
    logic              req_eob;
    logic              q_room;
    logic              fire;
    rled_pkg::t_push   push;
    rled_pkg::t_result head;

    assign fire = req_valid && q_room;

    rled_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_take          (fire),
        .o_valid         (req_valid),
        .o_data_byte     (req_byte),
        .o_end_of_buffer (req_eob)
    );

    rled_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (req_byte),
        .i_eob   (req_eob),
        .o_push  (push)
    );

    rled_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_out_ready),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_kind              = head.kind;
    assign o_run_start_virtual = head.start_virtual;
    assign o_run_cluster       = head.cluster;
    assign o_run_length        = head.length;
    assign o_sparse_run        = head.sparse;
    assign o_last_result       = head.last;

endmodule
